// ===== rtl/core/spm_pkg.sv =====
// Shared constants, types and helper functions for the Moore-neighborhood sandpile block.
// Depends on nothing; spm_cell_alu, the top level and the checker import it.
package spm_pkg;

  // Grid geometry and storage sizes. GRID_SIDE and CRIT_DEPTH are powers of two.
  localparam int GRID_SIDE  = 64;
  localparam int CRIT_DEPTH = 1024;
  localparam int CELL_BITS  = 8;

  localparam int COORD_W    = $clog2(GRID_SIDE);
  localparam int POS_W      = 2 * COORD_W;
  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int LIDX_W     = $clog2(CRIT_DEPTH);
  localparam int CNT_W      = $clog2(CRIT_DEPTH + 1);
  localparam int LRAM_DEPTH = 2 * CRIT_DEPTH;

  // Fixed field widths of the ports.
  localparam int CMD_W      = 2;
  localparam int ROW_W      = 6;
  localparam int VAL_W      = 8;
  localparam int SIDE_W     = 7;
  localparam int THR_W      = 8;
  localparam int LOST_W     = 14;
  localparam int PEND_W     = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Coordinate compare width: holds the side, a row and a row stepped off either edge.
  localparam int SC_W  = ($clog2(GRID_SIDE) + 2 > SIDE_W) ? $clog2(GRID_SIDE) + 2 : SIDE_W;
  // Compare width between cell values, written values and the threshold.
  localparam int CMP_W = (CELL_BITS > THR_W) ? CELL_BITS : THR_W;

  localparam logic [CELL_BITS-1:0] CELL_MAX = '1;

  // Stream packing.
  localparam int IN_DATA_W    = 24;
  localparam int IN_USER_W    = 2;
  localparam int IN_ROW_LSB   = 0;
  localparam int IN_COL_LSB   = 6;
  localparam int IN_VAL_LSB   = 12;
  localparam int OUT_DATA_W   = 32;
  localparam int OUT_LOST_LSB = 0;
  localparam int OUT_PEND_LSB = 14;
  localparam int OUT_CRIT_BIT = 25;
  localparam int OUT_OVF_BIT  = 26;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVOLVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THR  = 1'b1;

  localparam logic [2:0] NBR_LAST = 3'd7;

  // Result of the shared cell unit.
  typedef struct packed {
    logic [CELL_BITS-1:0] val;   // updated cell value
    logic                 ge;    // input cell was at or above threshold
    logic                 crit;  // updated value is at or above threshold
  } spm_alu_res_t;

  // Neighbor offsets in visiting order, as {row step, column step}.
  // Each step is 2'b01 for +1, 2'b00 for 0 and 2'b11 for -1; the center is skipped.
  function automatic logic [3:0] nbr_offset(input logic [2:0] n);
    logic [3:0] off;
    unique case (n)
      3'd0:    off = 4'b01_01;
      3'd1:    off = 4'b01_00;
      3'd2:    off = 4'b01_11;
      3'd3:    off = 4'b00_01;
      3'd4:    off = 4'b00_11;
      3'd5:    off = 4'b11_01;
      3'd6:    off = 4'b11_00;
      default: off = 4'b11_11;
    endcase
    return off;
  endfunction

endpackage

// ===== rtl/core/spm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module spm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/spm_cell_alu.sv =====
// Shared cell unit: saturating grain increment or threshold subtraction, plus threshold compares.
// Depends on spm_pkg.
module spm_cell_alu
  import spm_pkg::*;
(
  input  logic [CELL_BITS-1:0] cell_val,
  input  logic [THR_W-1:0]     thr,
  input  logic                 op_sub,
  output spm_alu_res_t         res
);

  logic [CMP_W-1:0]     cell_ext;
  logic [CMP_W-1:0]     thr_ext;
  logic [CELL_BITS-1:0] inc_val;
  logic [CELL_BITS-1:0] sub_val;

  always_comb begin
    cell_ext = CMP_W'(cell_val);
    thr_ext  = CMP_W'(thr);
    inc_val  = (cell_val == CELL_MAX) ? cell_val : cell_val + 1'b1;
    // Only used when the cell is at or above threshold, so the difference fits.
    sub_val  = CELL_BITS'(cell_ext - thr_ext);
    res.val  = op_sub ? sub_val : inc_val;
    res.ge   = cell_ext >= thr_ext;
    res.crit = CMP_W'(res.val) >= thr_ext;
  end

endmodule

// ===== rtl/core/sandpile_moore_toppling_top.sv =====
// Top level of the Moore-neighborhood sandpile: command sequencer, grid and critical lists.
// Depends on spm_pkg, spm_ram and spm_cell_alu.
//
//  Channel  | Signals                       | Payload
//  ---------+-------------------------------+-------------------------------------------
//  in_      | tvalid, tready, tdata, tuser  | tuser: cmd; tdata: row, col, value
//  out_     | tvalid, tready, tdata         | edge_loss, pending_count, crit, overflow
//  cfg_     | we, addr, wdata               | side_length (0), threshold (1)
//
// After reset the grid is cleared one cell per cycle, all 4096 cells; requests are refused
// meanwhile, configuration writes are taken. Write cell, no-op and an out-of-range add go from
// dispatch to the result; add grain reads the cell first. Evolve skips stale and sub-threshold
// list entries and topples the rest, a grain to each in-grid neighbor and one lost per off-grid
// neighbor, all through the one grid read port and the one shared cell unit.
// A finished result waits in the output register while the next request is accepted.
module sandpile_moore_toppling_top
  import spm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // row [5:0], col [11:6], value [19:12]
  input  logic [IN_USER_W-1:0]  in_tuser,   // cmd [1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // edge_loss [13:0], pending_count [24:14],
                                            // became_critical [25], overflow [26]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_ADD_RD   = 4'd3;
  localparam logic [3:0] S_EV_LREAD = 4'd4;
  localparam logic [3:0] S_EV_LDATA = 4'd5;
  localparam logic [3:0] S_EV_CDATA = 4'd6;
  localparam logic [3:0] S_EV_NADDR = 4'd7;
  localparam logic [3:0] S_EV_NDATA = 4'd8;
  localparam logic [3:0] S_EV_CENTER = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]           state_r, state_nxt;
  logic [POS_W-1:0]     clr_r, clr_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [ROW_W-1:0]     col_r, col_nxt;
  logic [VAL_W-1:0]     value_r, value_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [2:0]           nbr_r, nbr_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     npos_r, npos_nxt;
  logic                 center_crit_r, center_crit_nxt;
  logic [LOST_W-1:0]    lost_r, lost_nxt;
  logic [CNT_W-1:0]     cur_cnt_r, cur_cnt_nxt;
  logic [CNT_W-1:0]     nxt_cnt_r, nxt_cnt_nxt;
  logic                 bank_r, bank_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 crit_r, crit_nxt;
  logic [SIDE_W-1:0]    side_r, side_nxt;
  logic [THR_W-1:0]     thr_r, thr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Memory ports.
  logic                 grid_we, grid_re;
  logic [POS_W-1:0]     grid_waddr, grid_raddr;
  logic [CELL_BITS-1:0] grid_wdata, grid_rdata;
  logic                 list_we, list_re;
  logic [LIDX_W:0]      list_waddr, list_raddr;
  logic [POS_W-1:0]     list_wdata, list_rdata;

  // Shared cell unit.
  logic                 alu_sub;
  spm_alu_res_t         alu_res;

  // Append request to one of the critical lists.
  logic                 push_en;
  logic                 push_next;
  logic [POS_W-1:0]     push_pos;
  logic [CNT_W-1:0]     push_cnt;

  // Position decode.
  logic [SC_W-1:0]      side_used;
  logic [SC_W-1:0]      row_ext, col_ext;
  logic                 cmd_in_range;
  logic [POS_W-1:0]     cmd_pos;
  logic [CELL_BITS-1:0] write_val;
  logic [SC_W-1:0]      lrow, lcol;
  logic [SC_W-1:0]      prow, pcol, nrow, ncol;
  logic [3:0]           noff;

  spm_ram #(.WIDTH(CELL_BITS), .DEPTH(GRID_DEPTH)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .re    (grid_re),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  // Both critical lists share one RAM; the upper address bit picks the bank.
  spm_ram #(.WIDTH(POS_W), .DEPTH(LRAM_DEPTH)) u_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  spm_cell_alu u_alu (
    .cell_val (grid_rdata),
    .thr      (thr_r),
    .op_sub   (alu_sub),
    .res      (alu_res)
  );

  always_comb begin
    side_used    = (SC_W'(side_r) < SC_W'(GRID_SIDE)) ? SC_W'(side_r) : SC_W'(GRID_SIDE);
    row_ext      = SC_W'(row_r);
    col_ext      = SC_W'(col_r);
    cmd_in_range = (row_ext < side_used) && (col_ext < side_used);
    cmd_pos      = {row_ext[COORD_W-1:0], col_ext[COORD_W-1:0]};
    write_val    = (CMP_W'(value_r) > CMP_W'(CELL_MAX)) ? CELL_MAX : CELL_BITS'(value_r);
    lrow         = SC_W'(list_rdata[POS_W-1:COORD_W]);
    lcol         = SC_W'(list_rdata[COORD_W-1:0]);
    prow         = SC_W'(pos_r[POS_W-1:COORD_W]);
    pcol         = SC_W'(pos_r[COORD_W-1:0]);
    noff         = nbr_offset(nbr_r);
    // A step off row or column zero wraps to a large value and fails the side compare.
    nrow         = prow + {{(SC_W-2){noff[3]}}, noff[3:2]};
    ncol         = pcol + {{(SC_W-2){noff[1]}}, noff[1:0]};
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    cmd_nxt         = cmd_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    value_nxt       = value_r;
    k_nxt           = k_r;
    nbr_nxt         = nbr_r;
    pos_nxt         = pos_r;
    npos_nxt        = npos_r;
    center_crit_nxt = center_crit_r;
    lost_nxt        = lost_r;
    cur_cnt_nxt     = cur_cnt_r;
    nxt_cnt_nxt     = nxt_cnt_r;
    bank_nxt        = bank_r;
    ovf_nxt         = ovf_r;
    crit_nxt        = crit_r;
    side_nxt        = side_r;
    thr_nxt         = thr_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;

    grid_we    = 1'b0;
    grid_waddr = pos_r;
    grid_wdata = alu_res.val;
    grid_re    = 1'b0;
    grid_raddr = pos_r;
    list_re    = 1'b0;
    list_raddr = {bank_r, k_r[LIDX_W-1:0]};
    alu_sub    = 1'b0;
    push_en    = 1'b0;
    push_next  = 1'b0;
    push_pos   = pos_r;

    if (cfg_we) begin
      unique case (cfg_addr)
        REG_SIDE: side_nxt = cfg_wdata[SIDE_W-1:0];
        REG_THR:  thr_nxt  = cfg_wdata[THR_W-1:0];
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        grid_we    = 1'b1;
        grid_waddr = clr_r;
        grid_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == POS_W'(GRID_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser[CMD_W-1:0];
          row_nxt   = in_tdata[IN_ROW_LSB +: ROW_W];
          col_nxt   = in_tdata[IN_COL_LSB +: ROW_W];
          value_nxt = in_tdata[IN_VAL_LSB +: VAL_W];
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        crit_nxt = 1'b0;
        lost_nxt = '0;
        pos_nxt  = cmd_pos;
        unique case (cmd_r)
          CMD_WRITE: begin
            grid_we    = cmd_in_range;
            grid_waddr = cmd_pos;
            grid_wdata = write_val;
            state_nxt  = S_DONE;
          end
          CMD_ADD: begin
            grid_re    = cmd_in_range;
            grid_raddr = cmd_pos;
            state_nxt  = cmd_in_range ? S_ADD_RD : S_DONE;
          end
          CMD_EVOLVE: begin
            k_nxt       = '0;
            nxt_cnt_nxt = '0;
            state_nxt   = S_EV_LREAD;
          end
          CMD_NOP: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_ADD_RD: begin
        grid_we   = 1'b1;
        crit_nxt  = alu_res.crit;
        push_en   = alu_res.crit;
        state_nxt = S_DONE;
      end
      S_EV_LREAD: begin
        if (k_r < cur_cnt_r) begin
          list_re   = 1'b1;
          state_nxt = S_EV_LDATA;
        end else begin
          // The list built in this generation becomes the current one.
          bank_nxt    = ~bank_r;
          cur_cnt_nxt = nxt_cnt_r;
          state_nxt   = S_DONE;
        end
      end
      S_EV_LDATA: begin
        pos_nxt = list_rdata;
        if ((lrow < side_used) && (lcol < side_used)) begin
          grid_re    = 1'b1;
          grid_raddr = list_rdata;
          state_nxt  = S_EV_CDATA;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_EV_LREAD;
        end
      end
      S_EV_CDATA: begin
        alu_sub = 1'b1;
        if (alu_res.ge) begin
          grid_we         = 1'b1;
          center_crit_nxt = alu_res.crit;
          nbr_nxt         = '0;
          state_nxt       = S_EV_NADDR;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_EV_LREAD;
        end
      end
      S_EV_NADDR: begin
        if ((nrow < side_used) && (ncol < side_used)) begin
          grid_re    = 1'b1;
          grid_raddr = {nrow[COORD_W-1:0], ncol[COORD_W-1:0]};
          npos_nxt   = {nrow[COORD_W-1:0], ncol[COORD_W-1:0]};
          state_nxt  = S_EV_NDATA;
        end else begin
          if (lost_r != '1) begin
            lost_nxt = lost_r + 1'b1;
          end
          nbr_nxt = nbr_r + 1'b1;
          if (nbr_r == NBR_LAST) begin
            state_nxt = S_EV_CENTER;
          end
        end
      end
      S_EV_NDATA: begin
        grid_we    = 1'b1;
        grid_waddr = npos_r;
        push_en    = alu_res.crit;
        push_next  = 1'b1;
        push_pos   = npos_r;
        nbr_nxt    = nbr_r + 1'b1;
        state_nxt  = (nbr_r == NBR_LAST) ? S_EV_CENTER : S_EV_NADDR;
      end
      S_EV_CENTER: begin
        push_en   = center_crit_r;
        push_next = 1'b1;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_EV_LREAD;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[OUT_LOST_LSB +: LOST_W] = lost_r;
          out_data_nxt[OUT_PEND_LSB +: PEND_W] = PEND_W'(cur_cnt_r);
          out_data_nxt[OUT_CRIT_BIT]           = crit_r;
          out_data_nxt[OUT_OVF_BIT]            = ovf_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Add grain appends to the current list, evolve to the list of the next generation.
    push_cnt   = push_next ? nxt_cnt_r : cur_cnt_r;
    list_we    = 1'b0;
    list_waddr = {bank_r ^ push_next, push_cnt[LIDX_W-1:0]};
    list_wdata = push_pos;
    if (push_en) begin
      if (push_cnt < CNT_W'(CRIT_DEPTH)) begin
        list_we = 1'b1;
        if (push_next) begin
          nxt_cnt_nxt = push_cnt + 1'b1;
        end else begin
          cur_cnt_nxt = push_cnt + 1'b1;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cur_cnt_r   <= '0;
      nxt_cnt_r   <= '0;
      bank_r      <= 1'b0;
      ovf_r       <= 1'b0;
      side_r      <= SIDE_W'(64);
      thr_r       <= THR_W'(8);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_cnt_r   <= cur_cnt_nxt;
      nxt_cnt_r   <= nxt_cnt_nxt;
      bank_r      <= bank_nxt;
      ovf_r       <= ovf_nxt;
      side_r      <= side_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    row_r         <= row_nxt;
    col_r         <= col_nxt;
    value_r       <= value_nxt;
    k_r           <= k_nxt;
    nbr_r         <= nbr_nxt;
    pos_r         <= pos_nxt;
    npos_r        <= npos_nxt;
    center_crit_r <= center_crit_nxt;
    lost_r        <= lost_nxt;
    crit_r        <= crit_nxt;
    out_data_r    <= out_data_nxt;
  end

endmodule

// ===== rtl/core/spm_checker.sv =====
// Port-level checks for the sandpile top level, attached by the bind at the end of this file.
// Depends on spm_pkg and sandpile_moore_toppling_top.
module spm_checker
  import spm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A request is worked on in the states after its acceptance, so the block cannot take another at once.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or vanished");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_PEND_LSB +: PEND_W] <= PEND_W'(CRIT_DEPTH))
    else $error("pending count above list depth");

  // Grains are lost only by evolve, and only add grain reports a critical cell.
  a_lost_crit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[OUT_CRIT_BIT] && (out_tdata[OUT_LOST_LSB +: LOST_W] != '0)))
    else $error("result reports both lost grains and a critical add");

endmodule

bind sandpile_moore_toppling_top spm_checker u_spm_checker (.*);
